FILE: rtl/vole_alu_minifloat_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the minifloat ALU unit
// Short forms for the clocked checks used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef VOLE_ALU_MINIFLOAT_UNIT_MACROS_SVH
`define VOLE_ALU_MINIFLOAT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VAM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vam_pkg.sv
// ---------------------------------------------------------------------------
// vam_pkg
// Shared types and constants of the minifloat ALU unit.
// ---------------------------------------------------------------------------
package vam_pkg;

  localparam int REG_IDX_W = 4;
  localparam int DATA_W    = 8;
  localparam int FUNC_W    = 3;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [DATA_W-1:0]    byte_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_IADD = 3'd0,
    FN_FADD = 3'd1,
    FN_OR   = 3'd2,
    FN_AND  = 3'd3,
    FN_XOR  = 3'd4,
    FN_LOAD = 3'd5
  } func_t;

  // Minifloat: sign, 3-bit exponent (bias 3), 4-bit mantissa with hidden one.
  // Magnitudes are handled in 1/256 units; the largest sum needs 14 bits.
  localparam int MF_MAG_W    = 14;
  localparam int MF_SUM_W    = 15;
  localparam int MF_TOP_BIT  = 13;
  localparam int MF_MAX_LEAD = 12;
  localparam int MF_MIN_LEAD = 5;
  localparam logic [6:0] MF_SAT_MAG = 7'h7F;

  typedef struct packed {
    func_t    func;
    byte_t    a;
    byte_t    b;
    byte_t    d;
    byte_t    load_value;
  } alu_in_t;

  typedef struct packed {
    logic  wr;
    byte_t value;
  } alu_res_t;

endpackage

FILE: rtl/vole_alu_minifloat_unit.sv
// ---------------------------------------------------------------------------
// vole_alu_minifloat_unit
// Execute stage with a register file: integer, logic and minifloat ops.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid / in_stall  func, dest_reg, src_a_reg, src_b_reg, load_value
//  output   out_valid / out_stall written_reg, written_value
//
// Instructions pass the operand stage and result register; unless stalled, one may
// be accepted every cycle. The register file reads are registered at the input
// beat; the write of the instruction ahead is forwarded from the result
// register. Reset clears the file's written flags, so no clearing pass runs.
// A stalled output holds the instruction in the operand stage and stalls input.
// ---------------------------------------------------------------------------
module vole_alu_minifloat_unit #(
  parameter int NUM_REGS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        func,
  input  vam_pkg::reg_idx_t dest_reg,
  input  vam_pkg::reg_idx_t src_a_reg,
  input  vam_pkg::reg_idx_t src_b_reg,
  input  vam_pkg::byte_t    load_value,
  output logic              out_valid,
  input  logic              out_stall,
  output vam_pkg::reg_idx_t written_reg,
  output vam_pkg::byte_t    written_value
);
  import vam_pkg::*;

`include "vole_alu_minifloat_unit_macros.svh"

  localparam int AddrW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int ExtW  = (AddrW > REG_IDX_W) ? AddrW : REG_IDX_W;

  function automatic logic [AddrW-1:0] to_addr(reg_idx_t idx);
    logic [ExtW-1:0] ext;
    ext = ExtW'(idx);
    return ext[AddrW-1:0];
  endfunction

  function automatic logic in_range(reg_idx_t idx);
    return 32'(idx) < 32'(NUM_REGS);
  endfunction

  // Operand stage registers.
  logic        s1_valid;
  logic [2:0]  s1_func;
  reg_idx_t    s1_dest;
  byte_t       s1_load;
  logic        s1_dest_ok;
  logic        s1_a_ok, s1_b_ok, s1_d_ok;
  logic        s1_fwd_a, s1_fwd_b, s1_fwd_d;

  logic [NUM_REGS-1:0] written;

  logic        advance, s1_move, in_accept, wr_en;
  logic        fwd_a_next, fwd_b_next, fwd_d_next;
  byte_t       ram_a, ram_b, ram_d;
  alu_in_t     opnd;
  alu_res_t    res;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;
  assign s1_move   = s1_valid && advance;
  assign wr_en     = s1_move && res.wr && s1_dest_ok;

  // The item leaving the operand stage writes at the same edge as the read.
  assign fwd_a_next = wr_en && (s1_dest == src_a_reg);
  assign fwd_b_next = wr_en && (s1_dest == src_b_reg);
  assign fwd_d_next = wr_en && (s1_dest == dest_reg);

  vam_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS), .AW(AddrW)) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (to_addr(s1_dest)),
    .wdata (res.value),
    .re    (in_accept),
    .raddr (to_addr(src_a_reg)),
    .rdata (ram_a)
  );

  vam_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS), .AW(AddrW)) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (to_addr(s1_dest)),
    .wdata (res.value),
    .re    (in_accept),
    .raddr (to_addr(src_b_reg)),
    .rdata (ram_b)
  );

  vam_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS), .AW(AddrW)) u_ram_d (
    .clk   (clk),
    .we    (wr_en),
    .waddr (to_addr(s1_dest)),
    .wdata (res.value),
    .re    (in_accept),
    .raddr (to_addr(dest_reg)),
    .rdata (ram_d)
  );

  always_comb begin
    opnd.func       = func_t'(s1_func);
    opnd.load_value = s1_load;
    opnd.a = s1_fwd_a ? written_value : (s1_a_ok ? ram_a : '0);
    opnd.b = s1_fwd_b ? written_value : (s1_b_ok ? ram_b : '0);
    opnd.d = s1_fwd_d ? written_value : (s1_d_ok ? ram_d : '0);
  end

  vam_alu u_alu (
    .opnd (opnd),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      written   <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (wr_en) begin
        written[to_addr(s1_dest)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func    <= func;
      s1_dest    <= dest_reg;
      s1_load    <= load_value;
      s1_dest_ok <= in_range(dest_reg);
      s1_a_ok    <= in_range(src_a_reg) && written[to_addr(src_a_reg)];
      s1_b_ok    <= in_range(src_b_reg) && written[to_addr(src_b_reg)];
      s1_d_ok    <= in_range(dest_reg) && written[to_addr(dest_reg)];
      s1_fwd_a   <= fwd_a_next;
      s1_fwd_b   <= fwd_b_next;
      s1_fwd_d   <= fwd_d_next;
    end
    if (s1_move) begin
      written_reg   <= s1_dest;
      written_value <= res.value;
    end
  end

  `VAM_ASSERT_NEXT(a_fwd_source, in_accept && (fwd_a_next || fwd_b_next || fwd_d_next), out_valid && (written_reg == $past(s1_dest)), "forwarded operand is not in the result register")
  `VAM_ASSERT_NEXT(a_s1_hold, s1_valid && !advance, s1_valid && $stable(s1_dest) && $stable(s1_func), "operand stage changed while held")
  `VAM_ASSERT_IMPL(a_out_origin, $rose(out_valid), $past(s1_valid), "result beat without an instruction in the operand stage")

endmodule

FILE: rtl/vam_ram.sv
// ---------------------------------------------------------------------------
// vam_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module vam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/vam_mfadd.sv
// ---------------------------------------------------------------------------
// vam_mfadd
// Minifloat adder: exact fixed-point sum, normalised and truncated; saturates or flushes to zero at the range ends.
// ---------------------------------------------------------------------------
module vam_mfadd (
  input  vam_pkg::byte_t a,
  input  vam_pkg::byte_t b,
  output vam_pkg::byte_t sum
);
  import vam_pkg::*;

  // Magnitude in 1/256 units is (16 + m) << (e + 1).
  function automatic logic signed [MF_SUM_W-1:0] to_fix(byte_t v);
    logic [MF_MAG_W-1:0] mag;
    mag = MF_MAG_W'({1'b1, v[3:0]}) << ({1'b0, v[6:4]} + 4'd1);
    return v[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  logic signed [MF_SUM_W-1:0] fix_sum;
  logic [MF_MAG_W-1:0]        mag;
  logic [3:0]                 lead;
  logic [MF_MAG_W-1:0]        norm;
  logic                       neg;

  assign fix_sum = to_fix(a) + to_fix(b);
  assign neg     = fix_sum[MF_SUM_W-1];
  assign mag     = neg ? MF_MAG_W'(-fix_sum) : MF_MAG_W'(fix_sum);

  // Priority encoder: position of the leading one.
  always_comb begin
    lead = '0;
    for (int i = 0; i < MF_MAG_W; i++) begin
      if (mag[i]) begin
        lead = 4'(i);
      end
    end
  end

  assign norm = MF_MAG_W'(mag << (4'(MF_TOP_BIT) - lead));

  always_comb begin
    if (fix_sum == '0) begin
      sum = '0;
    end else if (lead > 4'(MF_MAX_LEAD)) begin
      sum = {neg, MF_SAT_MAG};
    end else if (lead < 4'(MF_MIN_LEAD)) begin
      sum = '0;
    end else begin
      sum = {neg, 3'(lead - 4'(MF_MIN_LEAD)), norm[MF_TOP_BIT-1 -: 4]};
    end
  end

endmodule

FILE: rtl/vam_alu.sv
// ---------------------------------------------------------------------------
// vam_alu
// Operation select: integer add, minifloat add, logic ops and load.
// ---------------------------------------------------------------------------
module vam_alu (
  input  vam_pkg::alu_in_t  opnd,
  output vam_pkg::alu_res_t res
);
  import vam_pkg::*;

  byte_t fsum;

  vam_mfadd u_mfadd (
    .a   (opnd.a),
    .b   (opnd.b),
    .sum (fsum)
  );

  always_comb begin
    res.wr = 1'b1;
    case (opnd.func)
      FN_IADD: res.value = opnd.a + opnd.b;
      FN_FADD: res.value = fsum;
      FN_OR:   res.value = opnd.a | opnd.b;
      FN_AND:  res.value = opnd.a & opnd.b;
      FN_XOR:  res.value = opnd.a ^ opnd.b;
      FN_LOAD: res.value = opnd.load_value;
      default: begin
        // Unused codes leave the file alone and report the destination.
        res.wr    = 1'b0;
        res.value = opnd.d;
      end
    endcase
  end

endmodule
